// ===== rtl/kpc_pkg.sv =====
// Shared types, codes and constants of the key press classifier.
`default_nettype none
package kpc_pkg;

    localparam int NUM_KEYS_DEF  = 3;
    localparam int TIME_BITS_DEF = 32;

    localparam int THRESH_BITS    = 16;
    localparam int KEY_CODE_BITS  = 8;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [THRESH_BITS-1:0] DEBOUNCE_MS_RST     = 16'd10;
    localparam logic [THRESH_BITS-1:0] LONG_PRESS_TIME_RST = 16'd1000;

    localparam logic [KEY_CODE_BITS-1:0] CODE_NONE = 8'h00;
    localparam logic [KEY_CODE_BITS-1:0] LONG_FLAG = 8'h80;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_MS     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS_TIME = 2'd1;

    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_CONFIRM  = 2'd1;
    localparam logic [1:0] PH_SHORT    = 2'd2;
    localparam logic [1:0] PH_LONG     = 2'd3;

    typedef struct packed {
        logic [THRESH_BITS-1:0] debounce_ms;
        logic [THRESH_BITS-1:0] long_press_time;
    } t_cfg;

    typedef struct packed {
        logic short_rel;
        logic long_rel;
    } t_key_event;

endpackage
`default_nettype wire

// ===== rtl/kpc_key_fsm.sv =====
// Press phase machine and press start time of one key.
`default_nettype none
module kpc_key_fsm #(
    parameter int TIME_BITS = kpc_pkg::TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic                 i_released,
    input  wire logic [TIME_BITS-1:0] i_now_time,
    input  wire kpc_pkg::t_cfg        i_cfg,
    output kpc_pkg::t_key_event       o_event
);
    import kpc_pkg::*;

    logic [1:0]           r_phase;
    logic [1:0]           n_phase;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] held;
    logic                 over_confirm;
    logic                 over_long;

    assign held         = i_now_time - r_start;
    assign over_confirm = held > TIME_BITS'(i_cfg.debounce_ms);
    assign over_long    = held > TIME_BITS'(i_cfg.long_press_time);

    always_comb begin
        n_phase = r_phase;
        o_event = '0;
        case (r_phase)
            PH_RELEASED: begin
                if (!i_released) n_phase = PH_CONFIRM;
            end
            PH_CONFIRM: begin
                if (i_released) n_phase = PH_RELEASED;
                else if (over_confirm) n_phase = PH_SHORT;
            end
            PH_SHORT: begin
                if (i_released) begin
                    n_phase = PH_RELEASED;
                    o_event.short_rel = 1'b1;
                end else if (over_long) begin
                    n_phase = PH_LONG;
                end
            end
            PH_LONG: begin
                if (i_released) begin
                    n_phase = PH_RELEASED;
                    o_event.long_rel = 1'b1;
                end
            end
            default: begin
                n_phase = PH_RELEASED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && r_phase == PH_RELEASED && !i_released) begin
            r_start <= i_now_time;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/key_press_classifier.sv =====
// Top level of the key press classifier: configuration, key chain and result register.
// The block takes one poll item per clock cycle and gives its key code in the cycle
// after acceptance from a single output register; input ready is high while that
// register is empty or being taken in the same cycle. Every key's phase machine and
// the priority chain that stops at the first reporting key sit in one combinational
// step between the key state registers and the output register.
`default_nettype none
module key_press_classifier #(
    parameter int NUM_KEYS  = kpc_pkg::NUM_KEYS_DEF,
    parameter int TIME_BITS = kpc_pkg::TIME_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [kpc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [kpc_pkg::THRESH_BITS-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [NUM_KEYS-1:0]                i_key_levels,
    input  wire logic [TIME_BITS-1:0]               i_now_time,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [kpc_pkg::KEY_CODE_BITS-1:0]       o_key_code
);
    import kpc_pkg::*;

    t_cfg                     r_cfg;
    logic                     r_out_valid;
    logic [KEY_CODE_BITS-1:0] r_key_code;
    logic [KEY_CODE_BITS-1:0] n_key_code;
    logic                     accept;
    t_key_event               key_event [NUM_KEYS];
    logic [NUM_KEYS:0]        blocked;
    logic [NUM_KEYS-1:0]      key_step;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_key_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= DEBOUNCE_MS_RST;
            r_cfg.long_press_time <= LONG_PRESS_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg_data;
                CFG_LONG_PRESS_TIME: r_cfg.long_press_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign blocked[0] = 1'b0;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        assign key_step[k]  = accept && !blocked[k];
        assign blocked[k+1] = blocked[k] || key_event[k].short_rel || key_event[k].long_rel;

        kpc_key_fsm #(
            .TIME_BITS (TIME_BITS)
        ) u_key (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (key_step[k]),
            .i_released (i_key_levels[k]),
            .i_now_time (i_now_time),
            .i_cfg      (r_cfg),
            .o_event    (key_event[k])
        );
    end

    always_comb begin
        n_key_code = CODE_NONE;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (key_event[k].short_rel) begin
                n_key_code = KEY_CODE_BITS'(k + 1);
            end else if (key_event[k].long_rel) begin
                n_key_code = LONG_FLAG | KEY_CODE_BITS'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_code <= n_key_code;
        end
    end

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item gave no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result is stalled");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_key_code != CODE_NONE) |->
            (o_key_code[6:0] >= 7'd1 && o_key_code[6:0] <= 7'(NUM_KEYS)))
        else $error("key code outside the key range");

endmodule
`default_nettype wire
